FILE: hdl/fmio_pkg.sv
// Shared types, constants and the binomial table function for the folded
// multi-index offset unit. No dependencies.
package fmio_pkg;

    localparam int MAX_ORDER  = 4;
    localparam int ELEM_W     = 8;
    localparam int ORDER_W    = 3;
    localparam int OFFSET_W   = 28;
    localparam int PADDR_W    = 2;
    localparam int PDATA_W    = 32;
    localparam int TAB_DEPTH  = 256;

    // Byte address of the num_vars register
    localparam logic [PADDR_W-1:0] ADDR_NUM_VARS = 2'd0;
    localparam logic [ELEM_W-1:0]  NUM_VARS_RST  = 8'd1;

    // Input commands
    localparam logic CMD_OFFSET    = 1'b0;
    localparam logic CMD_INCREMENT = 1'b1;

    typedef logic [ELEM_W-1:0] elem_t;

    typedef struct packed {
        logic                 cmd;
        logic [ORDER_W-1:0]   index_order;
        elem_t                elem_a;
        elem_t                elem_b;
        elem_t                elem_c;
        elem_t                elem_d;
    } in_t;

    typedef struct packed {
        logic [OFFSET_W-1:0]  folded_offset;
        elem_t                next_a;
        elem_t                next_b;
        elem_t                next_c;
        elem_t                next_d;
        logic                 past_end;
        logic                 bad_index;
    } out_t;

    // C(x+len-1, len): number of nondecreasing indexes of length len over x variables.
    // Only evaluated with constant arguments to build the lookup table.
    function automatic logic [OFFSET_W-1:0] fold_binom(input int x, input int len);
        longint v;
        v = longint'(x);
        case (len)
            2:       v = v * (v + 1) / 2;
            3:       v = v * (v + 1) * (v + 2) / 6;
            4:       v = v * (v + 1) * (v + 2) * (v + 3) / 24;
            default: v = longint'(x);
        endcase
        return v[OFFSET_W-1:0];
    endfunction

endpackage

FILE: hdl/folded_multi_index_offset_unit.sv
// Folded multi-index offset / increment unit, top level.
// Depends on fmio_pkg (types, constants, binomial table function).
//
//   port group   direction   handshake         payload
//   s_*          in          s_valid/s_ready   s_data  (fmio_pkg::in_t)
//   m_*          out         m_valid/m_ready   m_data  (fmio_pkg::out_t)
//   APB          in/out      psel/penable      paddr, pwdata, prdata
//
// A request passes the CHECK state, then for an offset a RUN_HI and a RUN_LO state per run
// of equal elements (one shared table read and one shared add/subtract each), for an
// increment the INC and CARRY states, repeated once per carry (at most three), plus the
// FIX state, then DONE, which loads the output register once it is free. s_ready is high
// only while the sequencer is idle; a finished result waits in the output register, so a
// new request is taken meanwhile.
// Reset is synchronous on aresetn low and needs no clearing pass.
module folded_multi_index_offset_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  fmio_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output fmio_pkg::out_t                    m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fmio_pkg::PADDR_W-1:0]      paddr,
    input  logic [fmio_pkg::PDATA_W-1:0]      pwdata,
    output logic [fmio_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_CHECK  = 8'b0000_0010,
        ST_RUN_HI = 8'b0000_0100,
        ST_RUN_LO = 8'b0000_1000,
        ST_INC    = 8'b0001_0000,
        ST_CARRY  = 8'b0010_0000,
        ST_FIX    = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t                            state_reg, state_next;
    fmio_pkg::elem_t                   num_vars_reg;
    logic                              m_valid_reg;
    fmio_pkg::out_t                    out_reg;

    logic                              cmd_reg;
    logic [fmio_pkg::ORDER_W-1:0]      ord_reg;
    fmio_pkg::elem_t                   elem_reg [fmio_pkg::MAX_ORDER];
    logic [fmio_pkg::ORDER_W-1:0]      pos_reg;
    logic [1:0]                        k_reg;
    fmio_pkg::elem_t                   sub_reg;
    fmio_pkg::elem_t                   nv_reg;
    logic [fmio_pkg::OFFSET_W-1:0]     acc_reg;
    logic                              bad_reg;

    logic [fmio_pkg::OFFSET_W-1:0]     binom_rom [fmio_pkg::MAX_ORDER][fmio_pkg::TAB_DEPTH];

    logic                              cfg_wr;
    logic                              out_free;
    logic [fmio_pkg::ORDER_W-1:0]      ord_clamp;
    logic                              chk_bad;
    fmio_pkg::elem_t                   in_elem [fmio_pkg::MAX_ORDER];
    fmio_pkg::elem_t                   cur_elem;
    fmio_pkg::elem_t                   cur;
    fmio_pkg::elem_t                   tab_x;
    logic [fmio_pkg::ORDER_W-1:0]      run_len;
    logic [1:0]                        len_idx;
    logic [fmio_pkg::OFFSET_W-1:0]     tab_val;
    logic [fmio_pkg::ORDER_W-1:0]      next_pos;
    fmio_pkg::elem_t                   fix_elem [fmio_pkg::MAX_ORDER];
    fmio_pkg::out_t                    result;

    // Constant binomial table, one row per run length
    for (genvar l = 0; l < fmio_pkg::MAX_ORDER; l++) begin : g_len
        for (genvar x = 0; x < fmio_pkg::TAB_DEPTH; x++) begin : g_x
            assign binom_rom[l][x] = fmio_pkg::fold_binom(x, l + 1);
        end
    end

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == fmio_pkg::ADDR_NUM_VARS);
    assign prdata = (paddr == fmio_pkg::ADDR_NUM_VARS) ?
                    {{(fmio_pkg::PDATA_W-fmio_pkg::ELEM_W){1'b0}}, num_vars_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_vars_reg <= fmio_pkg::NUM_VARS_RST;
        end else if (cfg_wr) begin
            num_vars_reg <= pwdata[fmio_pkg::ELEM_W-1:0];
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Range and order check on the captured request
    always_comb begin
        ord_clamp = (ord_reg > 3'(fmio_pkg::MAX_ORDER)) ? 3'(fmio_pkg::MAX_ORDER) : ord_reg;
        chk_bad   = (ord_reg > 3'(fmio_pkg::MAX_ORDER));
        for (int i = 0; i < fmio_pkg::MAX_ORDER; i++) begin
            if (3'(i) < ord_clamp) begin
                if (elem_reg[i] >= num_vars_reg) begin
                    chk_bad = 1'b1;
                end
                if (i > 0 && elem_reg[(i > 0) ? i - 1 : 0] > elem_reg[i]) begin
                    chk_bad = 1'b1;
                end
            end
        end
    end

    // Run walk: current element, run length and the start of the next run
    always_comb begin
        cur_elem = elem_reg[pos_reg[1:0]];
        cur      = cur_elem - sub_reg;
        tab_x    = (state_reg == ST_RUN_HI) ? nv_reg : nv_reg - cur;
        run_len  = ord_reg - pos_reg;
        len_idx  = 2'(run_len - 3'd1);
        tab_val  = binom_rom[len_idx][tab_x];
        next_pos = ord_reg;
        for (int j = fmio_pkg::MAX_ORDER - 1; j >= 0; j--) begin
            if (3'(j) > pos_reg && 3'(j) < ord_reg && elem_reg[j] != cur_elem) begin
                next_pos = 3'(j);
            end
        end
    end

    // Restore nondecreasing order after a carry
    always_comb begin
        fix_elem[0] = elem_reg[0];
        for (int i = 1; i < fmio_pkg::MAX_ORDER; i++) begin
            fix_elem[i] = (fix_elem[i-1] > elem_reg[i]) ? fix_elem[i-1] : elem_reg[i];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                priority if (chk_bad || ord_clamp == '0) begin
                    state_next = ST_DONE;
                end else if (cmd_reg == fmio_pkg::CMD_OFFSET) begin
                    state_next = ST_RUN_HI;
                end else begin
                    state_next = ST_INC;
                end
            end
            ST_RUN_HI: state_next = ST_RUN_LO;
            ST_RUN_LO: state_next = (next_pos == ord_reg) ? ST_DONE : ST_RUN_HI;
            ST_INC:    state_next = ST_CARRY;
            ST_CARRY: begin
                if (k_reg != '0 && elem_reg[k_reg] == num_vars_reg) begin
                    state_next = ST_INC;
                end else begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:    state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Assemble the result from the working registers
    always_comb begin
        result = '0;
        if (bad_reg) begin
            result.bad_index = 1'b1;
        end else if (cmd_reg == fmio_pkg::CMD_OFFSET) begin
            result.folded_offset = acc_reg;
        end else begin
            result.next_a   = (ord_reg > 3'd0) ? elem_reg[0] : '0;
            result.next_b   = (ord_reg > 3'd1) ? elem_reg[1] : '0;
            result.next_c   = (ord_reg > 3'd2) ? elem_reg[2] : '0;
            result.next_d   = (ord_reg > 3'd3) ? elem_reg[3] : '0;
            result.past_end = (ord_reg != '0) && (elem_reg[0] >= num_vars_reg);
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            out_reg <= result;
        end
        unique case (state_reg)
            ST_IDLE: begin
                cmd_reg     <= s_data.cmd;
                ord_reg     <= s_data.index_order;
                elem_reg[0] <= s_data.elem_a;
                elem_reg[1] <= s_data.elem_b;
                elem_reg[2] <= s_data.elem_c;
                elem_reg[3] <= s_data.elem_d;
                acc_reg     <= '0;
                bad_reg     <= 1'b0;
            end
            ST_CHECK: begin
                ord_reg <= ord_clamp;
                bad_reg <= chk_bad;
                pos_reg <= '0;
                sub_reg <= '0;
                nv_reg  <= num_vars_reg;
                k_reg   <= 2'(ord_clamp - 3'd1);
            end
            ST_RUN_HI: begin
                acc_reg <= acc_reg + tab_val;
            end
            ST_RUN_LO: begin
                acc_reg <= acc_reg - tab_val;
                sub_reg <= cur_elem;
                nv_reg  <= nv_reg - cur;
                pos_reg <= next_pos;
            end
            ST_INC: begin
                elem_reg[k_reg] <= elem_reg[k_reg] + 8'd1;
            end
            ST_CARRY: begin
                // wrap this digit and carry into the one before it
                if (k_reg != '0 && elem_reg[k_reg] == num_vars_reg) begin
                    elem_reg[k_reg] <= '0;
                    k_reg           <= k_reg - 2'd1;
                end
            end
            ST_FIX: begin
                for (int i = 0; i < fmio_pkg::MAX_ORDER; i++) begin
                    elem_reg[i] <= fix_elem[i];
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Run walk never leaves the index in use
    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN_HI || state_reg == ST_RUN_LO) |-> (pos_reg < ord_reg))
        else $error("run position beyond index order");

    // Remaining variable count covers the current element
    a_cur_below_nv: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN_LO) |-> (cur < nv_reg))
        else $error("run element not below remaining variable count");

    // A past-end result is a clean increment result
    a_past_end_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.past_end) |->
        (!out_reg.bad_index && out_reg.folded_offset == '0))
        else $error("past_end set together with offset or bad flag");

    // A result leaves the sequencer only into a free output register
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_valid_reg && !m_ready) |=> (state_reg == ST_DONE))
        else $error("result dropped while output register full");

endmodule

FILE: sim/tb_folded_multi_index_offset_unit.sv
// Self-checking testbench for folded_multi_index_offset_unit: offset and increment
// requests are predicted in the bench and compared field by field with each result.
// Depends on fmio_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_folded_multi_index_offset_unit;
    import fmio_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_SHOWN   = 10;
    localparam int DRAIN_WAIT  = 16;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_t                  s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_t                 m_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // bench copy of the num_vars register
    logic [ELEM_W-1:0]    num_vars_shadow;
    out_t                 pending_results[$];
    int                   mismatch_count = 0;
    int                   send_idle_pct  = 0;
    int                   ready_stall_pct = 0;
    int                   hold_off_cycles = 0;
    int                   cycle_count    = 0;

    folded_multi_index_offset_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // C(n, k), zero when k exceeds n
    function automatic longint unsigned choose(input longint unsigned n,
                                               input longint unsigned k);
        longint unsigned c;
        c = 1;
        if (k > n) return 0;
        for (longint unsigned i = 0; i < k; i++) c = c * (n - i) / (i + 1);
        return c;
    endfunction

    function automatic out_t predict_index_result(input in_t req);
        out_t          res;
        int unsigned   e[4];
        int unsigned   ord, pos, sub, nv, cur, run, len;
        int            k;
        logic          bad;
        longint unsigned total;

        res = '0;
        bad = 1'b0;
        e[0] = req.elem_a;
        e[1] = req.elem_b;
        e[2] = req.elem_c;
        e[3] = req.elem_d;
        ord = req.index_order;
        nv  = num_vars_shadow;
        if (ord > MAX_ORDER) begin
            bad = 1'b1;
            ord = MAX_ORDER;
        end
        for (int i = 0; i < ord; i++) begin
            if (e[i] >= nv) bad = 1'b1;
            if (i > 0 && e[i-1] > e[i]) bad = 1'b1;
        end
        if (bad) begin
            res.bad_index = 1'b1;
            return res;
        end

        if (req.cmd == CMD_OFFSET) begin
            total = 0;
            pos = 0;
            sub = 0;
            // one binomial pair per run of equal leading elements
            while (pos < ord) begin
                len = ord - pos;
                cur = e[pos] - sub;
                run = 1;
                while (pos + run < ord && e[pos+run] == e[pos]) run++;
                total += choose(nv + len - 1, len) - choose(nv - cur + len - 1, len);
                sub = e[pos];
                nv  = nv - cur;
                pos = pos + run;
            end
            res.folded_offset = total[OFFSET_W-1:0];
        end else if (ord > 0) begin
            k = ord - 1;
            e[k]++;
            while (k > 0 && e[k] == nv) begin
                e[k] = 0;
                k--;
                e[k]++;
            end
            for (int i = 1; i < ord; i++)
                if (e[i-1] > e[i]) e[i] = e[i-1];
            if (ord > 0) res.next_a = e[0][ELEM_W-1:0];
            if (ord > 1) res.next_b = e[1][ELEM_W-1:0];
            if (ord > 2) res.next_c = e[2][ELEM_W-1:0];
            if (ord > 3) res.next_d = e[3][ELEM_W-1:0];
            res.past_end = (e[0] >= nv);
        end
        return res;
    endfunction

    function automatic in_t make_index(input logic cmd, input int ord, input int a,
                                       input int b, input int c, input int d);
        in_t req;
        req.cmd         = cmd;
        req.index_order = ORDER_W'(ord);
        req.elem_a      = ELEM_W'(a);
        req.elem_b      = ELEM_W'(b);
        req.elem_c      = ELEM_W'(c);
        req.elem_d      = ELEM_W'(d);
        return req;
    endfunction

    // Mostly sorted in-range indexes biased to the edges, some broken ones, some noise
    function automatic in_t make_random_index(input logic [ELEM_W-1:0] nv);
        int unsigned e[4];
        int unsigned t;
        int          kind, ord, p;

        kind = $urandom_range(99, 0);
        if (kind < 10 || nv == 0)
            return make_index($urandom_range(1, 0), $urandom_range(7, 0),
                              $urandom_range(255, 0), $urandom_range(255, 0),
                              $urandom_range(255, 0), $urandom_range(255, 0));
        ord = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(4, 1);
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(3, 0))
                0:       e[i] = nv - 1;
                1:       e[i] = 0;
                default: e[i] = $urandom_range(nv - 1, 0);
            endcase
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3 - i; j++)
                if (e[j] > e[j+1]) begin
                    t      = e[j];
                    e[j]   = e[j+1];
                    e[j+1] = t;
                end
        // garbage in the unused positions
        for (int i = ord; i < 4; i++) e[i] = $urandom_range(255, 0);
        if (kind < 22 && ord > 0) begin
            p = $urandom_range(ord - 1, 0);
            if (p > 0 && e[p-1] > 0 && $urandom_range(1, 0))
                e[p] = e[p-1] - 1;
            else
                e[p] = $urandom_range(255, nv);
        end
        return make_index($urandom_range(1, 0), ord, e[0], e[1], e[2], e[3]);
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN)
                $display("mismatch in %s at cycle %0d: expected %0d, got %0d",
                         name, cycle_count, want, got);
        end
    endfunction

    // receiver: random stalls plus an optional long hold-off
    always @(negedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99, 0) >= ready_stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("unexpected result at cycle %0d: %h", cycle_count, m_data);
            end else begin
                want = pending_results.pop_front();
                check_field("folded_offset", want.folded_offset, m_data.folded_offset);
                check_field("next_a", want.next_a, m_data.next_a);
                check_field("next_b", want.next_b, m_data.next_b);
                check_field("next_c", want.next_c, m_data.next_c);
                check_field("next_d", want.next_d, m_data.next_d);
                check_field("past_end", want.past_end, m_data.past_end);
                check_field("bad_index", want.bad_index, m_data.bad_index);
            end
        end
    end

    task automatic send_request(input in_t req);
        @(negedge aclk);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_index_result(req));
    endtask

    task automatic wait_all_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_num_vars(input logic [ELEM_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_NUM_VARS;
        pwdata  <= PDATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        num_vars_shadow = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_random_phase(input int count, input logic [ELEM_W-1:0] nv,
                                    input int idle_pct, input int stall_pct);
        write_num_vars(nv);
        send_idle_pct   = idle_pct;
        ready_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) send_request(make_random_index(nv));
        wait_all_results();
    endtask

    // num_vars left at its reset value of one
    task automatic test_reset_value();
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        send_request(make_index(CMD_OFFSET, 0, 0, 0, 0, 0));
        send_request(make_index(CMD_OFFSET, 4, 0, 0, 0, 0));
        send_request(make_index(CMD_INCREMENT, 4, 0, 0, 0, 0));
        send_request(make_index(CMD_OFFSET, 1, 1, 0, 0, 0));
        wait_all_results();
    endtask

    task automatic test_directed_corners();
        write_num_vars(8'd255);
        send_request(make_index(CMD_OFFSET, 4, 254, 254, 254, 254));
        send_request(make_index(CMD_INCREMENT, 4, 254, 254, 254, 254));
        send_request(make_index(CMD_INCREMENT, 3, 0, 1, 254, 9));
        send_request(make_index(CMD_OFFSET, 3, 3, 2, 5, 0));
        send_request(make_index(CMD_OFFSET, 5, 0, 0, 0, 0));
        send_request(make_index(CMD_OFFSET, 6, 1, 2, 3, 4));
        send_request(make_index(CMD_INCREMENT, 7, 0, 0, 0, 0));
        send_request(make_index(CMD_INCREMENT, 2, 255, 255, 0, 0));
        send_request(make_index(CMD_OFFSET, 2, 0, 254, 255, 255));
        send_request(make_index(CMD_INCREMENT, 0, 255, 255, 255, 255));
        wait_all_results();
        // no variables: any element in use is out of range
        write_num_vars(8'd0);
        send_request(make_index(CMD_OFFSET, 0, 7, 7, 7, 7));
        send_request(make_index(CMD_INCREMENT, 1, 0, 0, 0, 0));
        send_request(make_index(CMD_OFFSET, 4, 0, 0, 0, 0));
        wait_all_results();
        write_num_vars(8'd3);
        send_request(make_index(CMD_INCREMENT, 4, 0, 2, 2, 2));
        send_request(make_index(CMD_INCREMENT, 4, 2, 2, 2, 2));
        send_request(make_index(CMD_OFFSET, 4, 0, 1, 1, 2));
        send_request(make_index(CMD_INCREMENT, 1, 2, 0, 0, 0));
        send_request(make_index(CMD_OFFSET, 3, 1, 1, 2, 8'hAA));
        wait_all_results();
    endtask

    task automatic test_streaming();
        run_random_phase(250, ELEM_W'($urandom_range(8, 2)), 0, 0);
        run_random_phase(60, 8'd1, 0, 0);
    endtask

    task automatic test_sender_gaps();
        run_random_phase(250, 8'd255, 70, 0);
    endtask

    task automatic test_receiver_stalls();
        run_random_phase(250, ELEM_W'($urandom_range(16, 1)), 0, 70);
    endtask

    task automatic test_mixed_idling();
        run_random_phase(125, ELEM_W'($urandom_range(255, 1)), 21, 21);
        run_random_phase(125, ELEM_W'($urandom_range(6, 2)), 21, 21);
    endtask

    // hold the result side off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        write_num_vars(8'd6);
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        hold_off_cycles = 400;
        for (int i = 0; i < 80; i++) send_request(make_random_index(8'd6));
        wait_all_results();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        num_vars_shadow = NUM_VARS_RST;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_value();
        test_directed_corners();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();
        test_backpressure();

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
